@@ sv/kdlr_pkg.sv @@
package kdlr_pkg;

  localparam int NUM_KEYS       = 3;
  localparam int NUM_SLOTS      = 2 * NUM_KEYS;
  localparam int SLOT_W         = $clog2(NUM_SLOTS);
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int FT_W       = 7;
  localparam int CNT_W      = FT_W + 1;
  localparam int TIME_W     = 16;
  localparam int KEY_W      = 2;
  localparam int KIND_W     = 2;
  localparam int ENTRY_W    = KEY_W + KIND_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [FT_W-1:0]   FT_RESET = FT_W'(5);
  localparam logic [TIME_W-1:0] LT_RESET = TIME_W'(20);
  localparam logic [TIME_W-1:0] RP_RESET = TIME_W'(50);
  localparam logic [CNT_W-1:0]  DB_RESET = CNT_W'(FT_RESET >> 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = CFG_IDX_W'(2);

  // request function codes
  localparam logic [1:0] FUNC_SCAN  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_DOWN = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_UP   = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_LONG = KIND_W'(2);

  typedef enum logic [1:0] {
    OP_SCAN,
    OP_POP,
    OP_CLEAR,
    OP_NONE
  } op_e;

  // classified request handed from front to back
  typedef struct packed {
    op_e                                op;
    logic [NUM_SLOTS-1:0]               ev_mask;
    logic [NUM_SLOTS-1:0][KIND_W-1:0]   ev_kind;
    logic [NUM_KEYS-1:0]                states;
  } pkt_t;

endpackage

@@ sv/kdlr_if.sv @@
interface kdlr_in_if import kdlr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [NUM_KEYS-1:0] pin_levels;

  modport source (output valid, func, pin_levels, input ready);
  modport sink   (input valid, func, pin_levels, output ready);
endinterface

interface kdlr_out_if import kdlr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                event_valid;
  logic [KEY_W-1:0]    event_key;
  logic [KIND_W-1:0]   event_kind;
  logic [NUM_KEYS-1:0] pressed_states;

  modport source (output valid, event_valid, event_key, event_kind, pressed_states,
                  input ready);
  modport sink   (input valid, event_valid, event_key, event_kind, pressed_states,
                  output ready);
endinterface

@@ sv/kdlr_front.sv @@
module kdlr_front import kdlr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kdlr_in_if.sink               in_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output pkt_t                  q_pkt_o
);

  logic [FT_W-1:0]   filter_q;
  logic [TIME_W-1:0] long_q, repeat_q;

  logic [NUM_KEYS-1:0][CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_KEYS-1:0]             flag_q, flag_d;
  logic [NUM_KEYS-1:0][TIME_W-1:0] hold_q, hold_d;
  logic [NUM_KEYS-1:0][TIME_W-1:0] rep_q, rep_d;
  logic [NUM_KEYS-1:0][TIME_W:0]   rep_inc;

  logic [NUM_SLOTS-1:0]             ev_mask;
  logic [NUM_SLOTS-1:0][KIND_W-1:0] ev_kind;
  logic [CNT_W-1:0]                 ft_lo, ft_hi;
  logic                             accept, is_scan;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign is_scan     = (in_if.func == FUNC_SCAN);
  assign ft_lo       = {1'b0, filter_q};
  assign ft_hi       = {filter_q, 1'b0};

  // per-key debounce, hold and repeat update
  always_comb begin
    cnt_d   = cnt_q;
    flag_d  = flag_q;
    hold_d  = hold_q;
    rep_d   = rep_q;
    ev_mask = '0;
    ev_kind = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      rep_inc[k] = {1'b0, rep_q[k]} + (TIME_W+1)'(1);
      if (!in_if.pin_levels[k]) begin
        if (cnt_q[k] < ft_lo) begin
          cnt_d[k] = ft_lo;
        end else if (cnt_q[k] < ft_hi) begin
          cnt_d[k] = cnt_q[k] + CNT_W'(1);
        end else begin
          if (!flag_q[k]) begin
            flag_d[k]      = 1'b1;
            ev_mask[2*k]   = 1'b1;
            ev_kind[2*k]   = KIND_DOWN;
          end
          if (long_q != '0) begin
            if (hold_q[k] < long_q) begin
              hold_d[k] = hold_q[k] + TIME_W'(1);
              if (hold_d[k] == long_q) begin
                ev_mask[2*k+1] = 1'b1;
                ev_kind[2*k+1] = KIND_LONG;
              end
            end else if (repeat_q != '0) begin
              if (rep_inc[k] >= {1'b0, repeat_q}) begin
                rep_d[k]       = '0;
                ev_mask[2*k+1] = 1'b1;
                ev_kind[2*k+1] = KIND_DOWN;
              end else begin
                rep_d[k] = rep_inc[k][TIME_W-1:0];
              end
            end
          end
        end
      end else begin
        if (cnt_q[k] > ft_lo) begin
          cnt_d[k] = ft_lo;
        end else if (cnt_q[k] != '0) begin
          cnt_d[k] = cnt_q[k] - CNT_W'(1);
        end else if (flag_q[k]) begin
          flag_d[k]    = 1'b0;
          ev_mask[2*k] = 1'b1;
          ev_kind[2*k] = KIND_UP;
        end
        hold_d[k] = '0;
        rep_d[k]  = '0;
      end
    end
  end

  // classify the request
  always_comb begin
    q_pkt_o = '0;
    unique case (in_if.func)
      FUNC_SCAN:  q_pkt_o.op = OP_SCAN;
      FUNC_POP:   q_pkt_o.op = OP_POP;
      FUNC_CLEAR: q_pkt_o.op = OP_CLEAR;
      default:    q_pkt_o.op = OP_NONE;
    endcase
    q_pkt_o.ev_mask = is_scan ? ev_mask : '0;
    q_pkt_o.ev_kind = ev_kind;
    q_pkt_o.states  = is_scan ? flag_d : flag_q;
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= FT_RESET;
      long_q   <= LT_RESET;
      repeat_q <= RP_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_q[k]  <= DB_RESET;
        hold_q[k] <= '0;
        rep_q[k]  <= '0;
      end
      flag_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FILTER: filter_q <= cfg_data_i[FT_W-1:0];
          REG_LONG:   long_q   <= cfg_data_i[TIME_W-1:0];
          REG_REPEAT: repeat_q <= cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (accept && is_scan) begin
        cnt_q  <= cnt_d;
        flag_q <= flag_d;
        hold_q <= hold_d;
        rep_q  <= rep_d;
      end
    end
  end

endmodule

@@ sv/kdlr_queue.sv @@
module kdlr_queue import kdlr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pkt_t pkt_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output pkt_t head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pkt_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i)  rd_q <= next_ptr(rd_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/kdlr_back.sv @@
module kdlr_back import kdlr_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  pkt_t      q_head_i,
  output logic      q_pop_o,
  kdlr_out_if.source out_if
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_FIN   = 4'b0100,
    S_READ  = 4'b1000
  } bstate_e;

  bstate_e state_q, state_d;

  logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
  logic [ENTRY_W-1:0] rdata_q, wdata;
  logic               mem_we;
  logic [PTR_W-1:0]   rp_q, rp_d, wp_q, wp_d;

  logic [NUM_SLOTS-1:0]             mask_q, mask_d, sel_hot;
  logic [NUM_SLOTS-1:0][KIND_W-1:0] kind_q, kind_d;
  logic [NUM_KEYS-1:0]              states_q, states_d;
  logic [SLOT_W-1:0]                sel_idx;
  logic                             last_write;

  logic                out_valid_q, out_valid_d;
  logic                out_ev_q, out_ev_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [NUM_KEYS-1:0] out_states_q, out_states_d;
  logic                out_free, fetch;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // lowest pending event slot
  always_comb begin
    sel_idx = '0;
    sel_hot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask_q[s]) begin
        sel_idx = SLOT_W'(s);
      end
    end
    sel_hot[sel_idx] = 1'b1;
  end

  assign last_write = ((mask_q & ~sel_hot) == '0);
  assign wdata      = {KEY_W'(sel_idx >> 1), kind_q[sel_idx]};
  assign out_free   = !out_valid_q || out_if.ready;
  assign fetch      = (state_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o    = fetch;

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    mask_d       = mask_q;
    kind_d       = kind_q;
    states_d     = states_q;
    mem_we       = 1'b0;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_ev_d     = out_ev_q;
    out_key_d    = out_key_q;
    out_kind_d   = out_kind_q;
    out_states_d = out_states_q;
    unique case (state_q)
      S_IDLE: begin
        if (fetch) begin
          mask_d   = q_head_i.ev_mask;
          kind_d   = q_head_i.ev_kind;
          states_d = q_head_i.states;
          if (q_head_i.op == OP_SCAN && q_head_i.ev_mask != '0) begin
            state_d = S_WRITE;
          end else if (q_head_i.op == OP_POP && rp_q != wp_q) begin
            state_d = S_READ;
          end else begin
            if (q_head_i.op == OP_CLEAR) wp_d = rp_q;
            out_valid_d  = 1'b1;
            out_ev_d     = 1'b0;
            out_key_d    = '0;
            out_kind_d   = '0;
            out_states_d = q_head_i.states;
          end
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        wp_d   = next_ptr(wp_q);
        mask_d = mask_q & ~sel_hot;
        if (last_write) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_ev_d     = 1'b0;
            out_key_d    = '0;
            out_kind_d   = '0;
            out_states_d = states_q;
            state_d      = S_IDLE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_ev_d     = 1'b0;
          out_key_d    = '0;
          out_kind_d   = '0;
          out_states_d = states_q;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_ev_d     = 1'b1;
          out_key_d    = rdata_q[ENTRY_W-1:KIND_W];
          out_kind_d   = rdata_q[KIND_W-1:0];
          out_states_d = states_q;
          rp_d         = next_ptr(rp_q);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // event memory, registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= wdata;
    end
    rdata_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    mask_q       <= mask_d;
    kind_q       <= kind_d;
    states_q     <= states_d;
    out_ev_q     <= out_ev_d;
    out_key_q    <= out_key_d;
    out_kind_q   <= out_kind_d;
    out_states_q <= out_states_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.event_valid    = out_ev_q;
  assign out_if.event_key      = out_key_q;
  assign out_if.event_kind     = out_kind_q;
  assign out_if.pressed_states = out_states_q;

  // a write cycle always has an event left to store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> mask_q != '0)
    else $error("write state with no pending event");

  // read pointer moves only when a popped event is delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q != $past(rp_q) |-> $past(state_q) == S_READ && $past(out_free))
    else $error("read pointer moved outside a pop");

  // clear leaves the event queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch && q_head_i.op == OP_CLEAR |=> wp_q == rp_q)
    else $error("clear did not empty the event queue");

  // a pop that found an event delivers it as valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ && out_free |=> out_valid_q && out_ev_q)
    else $error("popped event not presented");

endmodule

@@ sv/key_debounce_long_repeat_fifo_top.sv @@
// Keypad qualifier for three active-low buttons. Each request carries a
// function code: a scan tick debounces every key with a hysteresis counter
// spanning zero to twice filter_time and queues down, long, repeated down and
// up events into an event ring; a pop returns the oldest event (event_valid
// low when the ring is empty); a clear empties the ring. Every request gives
// exactly one response, which also shows the debounced pressed flags. The
// ring has no full check, so an overrun write that catches the read pointer
// leaves it empty. A front stage qualifies keys and classifies requests in
// the cycle they are taken and hands them through a two-entry queue to a back
// stage that owns the event memory. In the back stage, pop, clear and unused
// codes are answered at fetch, a pop that finds an event after the registered
// memory read, and a scan tick stores its queued events one at a time through
// the single write port of the event memory. The front keeps taking requests
// while the queue has room and the response register parts the output from the
// back stage. No memory clear runs after reset. Configuration is written through
// cfg_we_i with register 0 filter_time, 1 long_time and 2 repeat_period, while
// idle: a rule for the user that the block itself does not enforce.
module key_debounce_long_repeat_fifo_top import kdlr_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kdlr_in_if.sink               in_if,
  kdlr_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // front to queue
  logic q_push, q_full;
  pkt_t q_pkt;

  // queue to back
  logic q_pop, q_valid;
  pkt_t q_head;

  // key qualification, config registers, request classification
  kdlr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_pkt_o    (q_pkt)
  );

  // short request queue so each side can stall on its own
  kdlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pkt_i   (q_pkt),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // event ring writes, pops, clear and the response register
  kdlr_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

@@ tb/sv/tb_key_debounce_long_repeat_fifo_top.sv @@
`timescale 1ns / 1ps

module tb_key_debounce_long_repeat_fifo_top;
  import kdlr_pkg::*;

  localparam int RING_DEPTH     = FIFO_DEPTH_DEF;
  localparam int RING_PTR_W     = $clog2(RING_DEPTH);
  localparam int NUM_PHASES     = 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int MAX_REPORTS    = 10;

  // code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // one response as the block should present it
  typedef struct packed {
    logic                ev_valid;
    logic [KEY_W-1:0]    ev_key;
    logic [KIND_W-1:0]   ev_kind;
    logic [NUM_KEYS-1:0] states;
  } key_response_t;

  // tracks key qualification and the event ring, checks each response
  class key_event_scoreboard;
    logic [FT_W-1:0]       filt_ticks;
    logic [TIME_W-1:0]     long_ticks;
    logic [TIME_W-1:0]     repeat_ticks;
    logic [CNT_W-1:0]      db_cnt   [NUM_KEYS];
    bit                    pressed  [NUM_KEYS];
    logic [TIME_W-1:0]     hold_cnt [NUM_KEYS];
    logic [TIME_W-1:0]     rep_cnt  [NUM_KEYS];
    logic [ENTRY_W-1:0]    ring     [RING_DEPTH];
    logic [RING_PTR_W-1:0] rd_ptr;
    logic [RING_PTR_W-1:0] wr_ptr;
    key_response_t         pending_responses[$];
    int                    mismatches;
    int                    requests;
    int                    responses;
    int                    popped_events;
    int                    overruns;

    function new();
      filt_ticks   = FT_RESET;
      long_ticks   = LT_RESET;
      repeat_ticks = RP_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        db_cnt[k]   = DB_RESET;
        pressed[k]  = 1'b0;
        hold_cnt[k] = '0;
        rep_cnt[k]  = '0;
      end
      rd_ptr        = '0;
      wr_ptr        = '0;
      mismatches    = 0;
      requests      = 0;
      responses     = 0;
      popped_events = 0;
      overruns      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FILTER: filt_ticks   = data[FT_W-1:0];
        REG_LONG:   long_ticks   = data;
        REG_REPEAT: repeat_ticks = data;
        default: ;
      endcase
    endfunction

    // no room check: catching the read pointer empties the ring
    function void ring_put(int key, logic [KIND_W-1:0] kind);
      ring[wr_ptr] = {KEY_W'(key), kind};
      wr_ptr = wr_ptr + 1'b1;
      if (wr_ptr == rd_ptr) overruns++;
    endfunction

    function void scan_one_key(int k, bit down);
      int cnt;
      int ft;
      int r;
      cnt = db_cnt[k];
      ft  = filt_ticks;
      if (down) begin
        if (cnt < ft) cnt = ft;
        else if (cnt < 2 * ft) cnt++;
        else begin
          if (!pressed[k]) begin
            pressed[k] = 1'b1;
            ring_put(k, KIND_DOWN);
          end
          if (long_ticks != 0) begin
            if (hold_cnt[k] < long_ticks) begin
              hold_cnt[k] = hold_cnt[k] + 1'b1;
              if (hold_cnt[k] == long_ticks) ring_put(k, KIND_LONG);
            end else if (repeat_ticks != 0) begin
              r = int'(rep_cnt[k]) + 1;
              if (r >= int'(repeat_ticks)) begin
                r = 0;
                ring_put(k, KIND_DOWN);
              end
              rep_cnt[k] = r[TIME_W-1:0];
            end
          end
        end
      end else begin
        if (cnt > ft) cnt = ft;
        else if (cnt != 0) cnt--;
        else if (pressed[k]) begin
          pressed[k] = 1'b0;
          ring_put(k, KIND_UP);
        end
        hold_cnt[k] = '0;
        rep_cnt[k]  = '0;
      end
      db_cnt[k] = cnt[CNT_W-1:0];
    endfunction

    function void note_request(logic [1:0] func, logic [NUM_KEYS-1:0] pins);
      key_response_t rsp;
      rsp = '0;
      requests++;
      case (func)
        FUNC_SCAN: begin
          for (int k = 0; k < NUM_KEYS; k++) scan_one_key(k, pins[k] == 1'b0);
        end
        FUNC_POP: begin
          if (rd_ptr != wr_ptr) begin
            rsp.ev_valid = 1'b1;
            rsp.ev_key   = ring[rd_ptr][ENTRY_W-1:KIND_W];
            rsp.ev_kind  = ring[rd_ptr][KIND_W-1:0];
            rd_ptr       = rd_ptr + 1'b1;
            popped_events++;
          end
        end
        FUNC_CLEAR: wr_ptr = rd_ptr;
        default: ;
      endcase
      for (int k = 0; k < NUM_KEYS; k++) rsp.states[k] = pressed[k];
      pending_responses.push_back(rsp);
    endfunction

    function void report(string what, key_response_t want, key_response_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"response %0d: %s: expected valid %0b key %0d kind %0d states %b,",
                  " got valid %0b key %0d kind %0d states %b"},
                 responses, what, want.ev_valid, want.ev_key, want.ev_kind, want.states,
                 got.ev_valid, got.ev_key, got.ev_kind, got.states);
    endfunction

    function void check_response(key_response_t got);
      key_response_t want;
      responses++;
      if (pending_responses.size() == 0) begin
        report("no request pending", '0, got);
        return;
      end
      want = pending_responses.pop_front();
      if (got !== want) report("field mismatch", want, got);
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  kdlr_in_if  in_if ();
  kdlr_out_if out_if ();

  key_debounce_long_repeat_fifo_top #(
    .FIFO_DEPTH(RING_DEPTH)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  key_event_scoreboard sb = new();

  // idle percentages per side, changed between phases
  int src_idle_pct;
  int snk_idle_pct;

  // long receiver hold-off: requested by stimulus, counted by the receiver
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;

  // intended key positions, 1 means the finger is on the key
  logic [NUM_KEYS-1:0] held_keys;

  int cycle_count = 0;

  // register settings per phase: filter zero, long/repeat disabled, and the maxima
  int phase_ft    [NUM_PHASES] = '{0, 1, 2, 3, 127, 0, 1, 4};
  int phase_lt    [NUM_PHASES] = '{1, 3, 5, 0, 65535, 65535, 2, 7};
  int phase_rp    [NUM_PHASES] = '{1, 2, 0, 4, 65535, 1, 65535, 3};
  int phase_items [NUM_PHASES] = '{150, 140, 130, 130, 200, 80, 130, 130};

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog against a hung handshake
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles with %0d responses pending", cycle_count,
             sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // response side: check what was taken at this edge, then choose next ready
  always @(posedge clk_i) begin
    key_response_t seen;
    if (out_if.valid && out_if.ready) begin
      seen = {out_if.event_valid, out_if.event_key, out_if.event_kind, out_if.pressed_states};
      sb.check_response(seen);
    end
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req <= 1'b0;
    end
    if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // offer one request, with random idle cycles ahead of it; valid stays high
  // after acceptance so back-to-back requests need no second assignment
  task automatic send_request(logic [1:0] func, logic [NUM_KEYS-1:0] pins);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.pin_levels <= pins;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(func, pins);
  endtask

  // stop offering and wait for every response to come back
  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // all three registers, written only while the block is idle
  task automatic write_all_regs(int ft, int lt, int rp);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_FILTER;
    cfg_data <= CFG_DATA_W'(ft);
    @(posedge clk_i);
    sb.write_reg(REG_FILTER, CFG_DATA_W'(ft));
    cfg_idx  <= REG_LONG;
    cfg_data <= CFG_DATA_W'(lt);
    @(posedge clk_i);
    sb.write_reg(REG_LONG, CFG_DATA_W'(lt));
    cfg_idx  <= REG_REPEAT;
    cfg_data <= CFG_DATA_W'(rp);
    @(posedge clk_i);
    sb.write_reg(REG_REPEAT, CFG_DATA_W'(rp));
    cfg_we <= 1'b0;
  endtask

  // mostly scan ticks with keys held for stretches long enough to qualify,
  // plus single-tick bounces, pops, clears and the unused code
  task automatic run_random_items(int n, int ft, int scan_pct, int hold_at, int pause_at);
    int                  r;
    logic [NUM_KEYS-1:0] noise;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_until_drained();
      if (i == hold_at) rx_hold_req <= 1'b1;
      r = $urandom_range(99);
      if (r < scan_pct) begin
        // change of finger position, rarer when the filter is long
        if ($urandom_range(2 * ft + 10) == 0) begin
          r = $urandom_range(NUM_KEYS - 1);
          held_keys[r] = ~held_keys[r];
        end
        noise = '0;
        if ($urandom_range(ft + 9) == 0) noise[$urandom_range(NUM_KEYS - 1)] = 1'b1;
        send_request(FUNC_SCAN, ~held_keys ^ noise);
      end else if (r < 92) begin
        send_request(FUNC_POP, NUM_KEYS'($urandom));
      end else if (r < 96) begin
        send_request(FUNC_CLEAR, NUM_KEYS'($urandom));
      end else begin
        send_request(FUNC_UNUSED, NUM_KEYS'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_SCAN;
    in_if.pin_levels = '1;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_FILTER;
    cfg_data         = '0;
    held_keys        = '0;
    // first idle mix: sender idles less than receiver
    src_idle_pct     = 29;
    snk_idle_pct     = 58;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    // pop of an empty ring, unused code, clear of an empty ring
    send_request(FUNC_POP, '0);
    send_request(FUNC_UNUSED, '0);
    send_request(FUNC_CLEAR, '1);
    send_request(FUNC_POP, '1);
    // all three keys pressed long enough to qualify
    repeat (8) send_request(FUNC_SCAN, '0);
    // three down events, then the ring runs dry
    repeat (4) send_request(FUNC_POP, '0);
    // release every key until the up events are queued
    repeat (7) send_request(FUNC_SCAN, '1);
    repeat (2) send_request(FUNC_POP, 3'b101);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_until_drained();
      // second idle mix swaps the sides, the last one has no idling
      if (ph == 3) begin
        src_idle_pct = 58;
        snk_idle_pct = 29;
      end
      if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // settings change while keys may still be held: counters meet new limits
      write_all_regs(phase_ft[ph], phase_lt[ph], phase_rp[ph]);
      run_random_items(phase_items[ph], phase_ft[ph], (phase_ft[ph] > 64) ? 85 : 55,
                       (ph == 6) ? 30 : -1, (ph == 3) ? 50 : -1);
    end

    wait_until_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests over %0d register settings with stalls on both sides",
             sb.requests, NUM_PHASES + 1);
    $display("%0d events popped, %0d ring overruns, %0d mismatches", sb.popped_events,
             sb.overruns, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
